/* rtl/hse_pkg.sv */
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the hall sensor speed estimator.
// ----------------------------------------------------------------------------
package hse_pkg;

  // Item kinds on the input channel (code 3 is unused and changes nothing)
  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_SYNC  = 2'd2
  } kind_e;

  // Query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PP,
    ST_MUL_DIV,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_ACC
  } state_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TPR     = 2'd0;
  localparam logic [1:0] CFG_POLES   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_ALPHA   = 2'd3;

  // 60 s/min * 1e6 us/s * 256 (Q24.8), fits in 34 bits
  localparam int          NUM_W     = 34;
  localparam logic [33:0] SPEED_NUM = 34'd15360000000;

  // Divisor width: 8-bit x 8-bit x 32-bit interval
  localparam int DVS_W = 48;

  // Filter weight of 1.0 in Q1.16
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

endpackage

/* rtl/hall_speed_estimator.sv */
// ----------------------------------------------------------------------------
// hall_speed_estimator
// Hall sensor edge period measurement with a first-order speed filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word per event: a hall
//   edge, a speed query or a sync. Every word yields exactly one result word
//   on the output channel (out_valid_o/out_ready_i) with the hall state, the
//   filtered speed in Q24.8 rpm and the stopped flag.
//   Edge, sync, unused kinds and stopped queries: the result is registered
//   and shown in the cycle after accept. A running query makes two passes
//   through the shared 17x32 multiplier for the divisor, runs the bit-serial
//   divider, then two more multiplier passes and one add for the filter.
//   One word is in flight at a time; in_ready_o is high only while the
//   sequencer idles and the output register is empty or being drained.
//   A stalled receiver holds the result in the output register and blocks
//   further input until it is taken.
//   Configuration words (cfg_valid_i/cfg_ready_o) are always taken; write
//   them only while the block is idle.
//   Reset clears edge time, interval, hall state and filter, and loads the
//   default configuration (6 transitions, 16 pole pairs, 100 ms timeout,
//   alpha 0.2).
// ----------------------------------------------------------------------------
module hall_speed_estimator import hse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] time_us_i,
  input  logic [2:0]  hall_pins_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  hall_state_o,
  output logic [31:0] speed_q8_o,
  output logic        stopped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration
  logic [7:0]  tpr_q;
  logic [7:0]  poles_q;
  logic [31:0] timeout_q;
  logic [16:0] alpha_q;

  // Estimator state
  logic [31:0] last_time_q;
  logic [31:0] interval_q;
  logic [2:0]  sensor_q;
  logic [31:0] filt_q;

  // Sequencer and datapath
  state_e      state_q, state_d;
  logic [48:0] mul_q;
  logic [48:0] new_q;
  logic [31:0] raw_q;
  logic [16:0] mul_a;
  logic [31:0] mul_b;
  logic [48:0] mul_p;
  logic        div_start;
  logic        div_done;
  logic [NUM_W-1:0] div_quo;
  logic [31:0] raw_sat;
  logic [47:0] acc;

  // Output register
  logic        out_valid_q;
  logic [2:0]  out_state_q;
  logic [31:0] out_speed_q;
  logic        out_stop_q;

  logic        in_fire;
  logic [31:0] elapsed;
  logic        stop_hit;
  logic [16:0] alpha_c;
  logic [16:0] alpha_inv;

  assign in_fire   = in_valid_i & in_ready_o;
  assign elapsed   = time_us_i - last_time_q;
  assign stop_hit  = (interval_q == '0) || (elapsed > timeout_q);
  assign alpha_c   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign alpha_inv = ALPHA_ONE - alpha_c;
  assign mul_p     = 49'(mul_a) * 49'(mul_b);
  assign raw_sat   = (|div_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
  assign acc       = new_q[47:0] + mul_q[47:0];

  // Bit-serial divider
  hse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (mul_q[DVS_W-1:0]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (kind_i == KIND_QUERY) && !stop_hit) begin
          state_d = ST_MUL_PP;
        end
      end
      ST_MUL_PP:    state_d = ST_MUL_DIV;
      ST_MUL_DIV:   state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = ST_MUL_NEW;
        end
      end
      ST_MUL_NEW:   state_d = ST_MUL_OLD;
      ST_MUL_OLD:   state_d = ST_ACC;
      ST_ACC:       state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start and multiplier operand select
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_IDLE:      in_ready_o = !out_valid_q || out_ready_i;
      ST_MUL_PP: begin
        mul_a = {9'd0, tpr_q};
        mul_b = {24'd0, poles_q};
      end
      ST_MUL_DIV: begin
        mul_a = {1'b0, mul_q[15:0]};
        mul_b = interval_q;
      end
      ST_DIV_START: div_start = 1'b1;
      ST_MUL_NEW: begin
        mul_a = alpha_c;
        mul_b = raw_q;
      end
      ST_MUL_OLD: begin
        mul_a = alpha_inv;
        mul_b = filt_q;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpr_q     <= 8'd6;
      poles_q   <= 8'd16;
      timeout_q <= 32'd100000;
      alpha_q   <= 17'd13107;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TPR:     tpr_q     <= cfg_data_i[7:0];
        CFG_POLES:   poles_q   <= cfg_data_i[7:0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_ALPHA:   alpha_q   <= cfg_data_i[16:0];
        default:     tpr_q     <= tpr_q;
      endcase
    end
  end

  // Sequencer state, estimator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_time_q <= '0;
      interval_q  <= '0;
      sensor_q    <= '0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
      out_state_q <= '0;
      out_speed_q <= '0;
      out_stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // drain a taken result
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            out_state_q <= sensor_q;
            out_speed_q <= filt_q;
            out_stop_q  <= 1'b0;
            out_valid_q <= 1'b1;
            case (kind_i)
              KIND_EDGE: begin
                interval_q  <= elapsed;
                last_time_q <= time_us_i;
                sensor_q    <= ~hall_pins_i;
                out_state_q <= ~hall_pins_i;
              end
              KIND_SYNC: begin
                last_time_q <= time_us_i;
                sensor_q    <= ~hall_pins_i;
                out_state_q <= ~hall_pins_i;
              end
              KIND_QUERY: begin
                if (stop_hit) begin
                  filt_q      <= '0;
                  out_speed_q <= '0;
                  out_stop_q  <= 1'b1;
                end else begin
                  // hold the result back until the filter is done
                  out_valid_q <= 1'b0;
                end
              end
              default: begin
                out_stop_q <= 1'b0;
              end
            endcase
          end
        end
        ST_ACC: begin
          filt_q      <= acc[47:16];
          out_state_q <= sensor_q;
          out_speed_q <= acc[47:16];
          out_stop_q  <= 1'b0;
          out_valid_q <= 1'b1;
        end
        default: begin
          filt_q <= filt_q;
        end
      endcase
    end
  end

  // Multiplier result, filter partial product and saturated raw speed
  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    if (state_q == ST_MUL_OLD) begin
      new_q <= mul_q;
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      raw_q <= raw_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hall_state_o = out_state_q;
  assign speed_q8_o   = out_speed_q;
  assign stopped_o    = out_stop_q;

endmodule

/* rtl/hse_div.sv */
// ----------------------------------------------------------------------------
// hse_div
// Bit-serial restoring divider: constant speed numerator over a 48-bit
// divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hse_div import hse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVS_W-1:0]     divisor_i,
  output logic                 done_o,
  output logic [NUM_W-1:0]     quotient_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q;
  logic [NUM_W-1:0] dvs_q;
  logic             big_q;

  logic [NUM_W:0]   rem_shift;
  logic [NUM_W:0]   rem_diff;
  logic             fits;

  // Shift in the next numerator bit and trial-subtract
  assign rem_shift = {rem_q, quo_q[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs_q};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign rem_d     = fits ? rem_diff[NUM_W-1:0] : rem_shift[NUM_W-1:0];

  // Control: run for one step per quotient bit, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: quotient bits replace numerator bits as they shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= SPEED_NUM;
      dvs_q <= divisor_i[NUM_W-1:0];
      big_q <= |divisor_i[DVS_W-1:NUM_W];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  // A divisor above the numerator gives zero
  assign done_o     = done_q;
  assign quotient_o = big_q ? '0 : quo_q;

endmodule
